FILE: hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared definitions for the linear probing hash table
// Table geometry, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_IDX_W   = $clog2(KEY_WIDTH);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_PROBE,
        S_COMPARE,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Inserts or searches 16-bit keys; the home bucket is key mod bucket_count.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Direction
//  input     valid, ready, mode, key_value            item in
//  output    out_valid, out_ready, status, bucket_index  item out
//  config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB
//
// An item first passes the restoring shift-subtract unit that forms key mod
// bucket_count, then the probe walk (a probe state per insert probe, a probe and
// a compare state per search probe of an occupied slot, since the key RAM read is
// registered), then a done state that hands off the result once the output is free.
// The one subtractor serves both the remainder steps and the probe wrap test.
// Reset empties the table at once through the per-slot used flags.
// input ready is high only in the idle state; a finished item waits in the
// output register while the next item is already accepted.
//
module linear_probe_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        mode,
    input  logic [15:0] key_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  bucket_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lpht_pkg::state_t state_reg, state_next;

    logic [lpht_pkg::CNT_W-1:0]     bucket_count_reg;
    logic [lpht_pkg::CNT_W-1:0]     n_reg, n_next;
    logic                           mode_reg, mode_next;
    logic [lpht_pkg::KEY_WIDTH-1:0] key_reg, key_next;
    logic [lpht_pkg::KEY_IDX_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [lpht_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [lpht_pkg::IDX_W-1:0]     slot_reg, slot_next;
    logic [lpht_pkg::CNT_W-1:0]     probe_cnt_reg, probe_cnt_next;
    logic [1:0]                     res_status_reg, res_status_next;
    logic [lpht_pkg::IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     status_reg, status_next;
    logic [lpht_pkg::IDX_W-1:0]     bucket_index_reg, bucket_index_next;
    logic [lpht_pkg::TABLE_DEPTH-1:0] used_reg, used_next;

    logic                           cfg_write;
    logic [lpht_pkg::CNT_W-1:0]     n_eff;
    logic [lpht_pkg::CNT_W-1:0]     shifted;
    logic [lpht_pkg::CNT_W-1:0]     sub_a;
    logic [lpht_pkg::CNT_W:0]       sub_diff;
    logic                           sub_borrow;
    logic [lpht_pkg::CNT_W-1:0]     cnt_inc;
    logic                           last_probe;
    logic                           slot_used;
    logic                           key_match;
    logic                           out_free;
    logic                           accept;

    logic                           ram_we;
    logic [lpht_pkg::KEY_WIDTH-1:0] ram_rdata;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == lpht_pkg::REG_BUCKET_COUNT);
    assign prdata    = (paddr[2] == lpht_pkg::REG_BUCKET_COUNT)
                       ? {{(32 - lpht_pkg::CNT_W){1'b0}}, bucket_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= lpht_pkg::DEPTH_CNT;
        end
        else if (cfg_write)
        begin
            bucket_count_reg <= pwdata[lpht_pkg::CNT_W-1:0];
        end
    end

    // A count of zero behaves as one bucket, a count above the depth as the depth.
    assign n_eff = (bucket_count_reg == '0) ? lpht_pkg::CNT_W'(1)
                 : (bucket_count_reg > lpht_pkg::DEPTH_CNT) ? lpht_pkg::DEPTH_CNT
                 : bucket_count_reg;

    assign ready  = (state_reg == lpht_pkg::S_IDLE);
    assign accept = valid && ready;

    // Shared subtractor: remainder step while dividing, wrap test while probing.
    assign shifted    = {rem_reg[lpht_pkg::CNT_W-2:0], key_reg[bit_cnt_reg]};
    assign sub_a      = (state_reg == lpht_pkg::S_DIVIDE) ? shifted
                      : {1'b0, slot_reg} + lpht_pkg::CNT_W'(1);
    assign sub_diff   = {1'b0, sub_a} - {1'b0, n_reg};
    assign sub_borrow = sub_diff[lpht_pkg::CNT_W];

    assign cnt_inc    = probe_cnt_reg + lpht_pkg::CNT_W'(1);
    assign last_probe = (cnt_inc == n_reg);
    assign slot_used  = used_reg[slot_reg];
    assign key_match  = (ram_rdata == key_reg);
    assign out_free   = !out_valid_reg || out_ready;

    lpht_ram #(
        .WIDTH(lpht_pkg::KEY_WIDTH),
        .DEPTH(lpht_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_reg),
        .wdata(key_reg),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpht_pkg::S_DIVIDE;
                end
            end
            lpht_pkg::S_DIVIDE:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (!slot_used)
                begin
                    state_next = lpht_pkg::S_DONE;
                end
                else if (mode_reg == lpht_pkg::MODE_SEARCH)
                begin
                    state_next = lpht_pkg::S_COMPARE;
                end
                else if (last_probe)
                begin
                    state_next = lpht_pkg::S_DONE;
                end
            end
            lpht_pkg::S_COMPARE:
            begin
                if (key_match || last_probe)
                begin
                    state_next = lpht_pkg::S_DONE;
                end
                else
                begin
                    state_next = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        n_next            = n_reg;
        mode_next         = mode_reg;
        key_next          = key_reg;
        bit_cnt_next      = bit_cnt_reg;
        rem_next          = rem_reg;
        slot_next         = slot_reg;
        probe_cnt_next    = probe_cnt_reg;
        res_status_next   = res_status_reg;
        res_idx_next      = res_idx_reg;
        used_next         = used_reg;
        ram_we            = 1'b0;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        bucket_index_next = bucket_index_reg;

        unique case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    n_next       = n_eff;
                    mode_next    = mode;
                    key_next     = key_value;
                    bit_cnt_next = lpht_pkg::KEY_IDX_W'(lpht_pkg::KEY_WIDTH - 1);
                    rem_next     = '0;
                end
            end
            lpht_pkg::S_DIVIDE:
            begin
                rem_next     = sub_borrow ? shifted : sub_diff[lpht_pkg::CNT_W-1:0];
                bit_cnt_next = bit_cnt_reg - lpht_pkg::KEY_IDX_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    slot_next      = rem_next[lpht_pkg::IDX_W-1:0];
                    probe_cnt_next = '0;
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (!slot_used)
                begin
                    if (mode_reg == lpht_pkg::MODE_INSERT)
                    begin
                        ram_we              = 1'b1;
                        used_next[slot_reg] = 1'b1;
                        res_status_next     = lpht_pkg::ST_INSERTED;
                        res_idx_next        = slot_reg;
                    end
                    else
                    begin
                        res_status_next = lpht_pkg::ST_NOT_FOUND;
                        res_idx_next    = '0;
                    end
                end
                else if (mode_reg == lpht_pkg::MODE_INSERT)
                begin
                    if (last_probe)
                    begin
                        res_status_next = lpht_pkg::ST_OVERFLOW;
                        res_idx_next    = '0;
                    end
                    else
                    begin
                        probe_cnt_next = cnt_inc;
                        slot_next      = (sub_diff == '0) ? '0
                                       : sub_a[lpht_pkg::IDX_W-1:0];
                    end
                end
            end
            lpht_pkg::S_COMPARE:
            begin
                if (key_match)
                begin
                    res_status_next = lpht_pkg::ST_FOUND;
                    res_idx_next    = slot_reg;
                end
                else if (last_probe)
                begin
                    res_status_next = lpht_pkg::ST_NOT_FOUND;
                    res_idx_next    = '0;
                end
                else
                begin
                    probe_cnt_next = cnt_inc;
                    slot_next      = (sub_diff == '0) ? '0
                                   : sub_a[lpht_pkg::IDX_W-1:0];
                end
            end
            lpht_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    bucket_index_next = res_idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        mode_reg         <= mode_next;
        key_reg          <= key_next;
        bit_cnt_reg      <= bit_cnt_next;
        rem_reg          <= rem_next;
        slot_reg         <= slot_next;
        probe_cnt_reg    <= probe_cnt_next;
        res_status_reg   <= res_status_next;
        res_idx_reg      <= res_idx_next;
        status_reg       <= status_next;
        bucket_index_reg <= bucket_index_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign bucket_index = bucket_index_reg;

    // The partial remainder always stays below the divisor.
    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_DIVIDE) |-> (rem_reg < n_reg))
        else $error("partial remainder reached bucket count");

    // A probe walk never runs past one full circle.
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_PROBE || state_reg == lpht_pkg::S_COMPARE)
        |-> (probe_cnt_reg < n_reg && {1'b0, slot_reg} < n_reg))
        else $error("probe walk left the buckets in use");

    // A successful insert leaves its slot marked used.
    a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_DONE && res_status_reg == lpht_pkg::ST_INSERTED)
        |-> used_reg[res_idx_reg])
        else $error("inserted slot not marked used");

    // A found key comes from an occupied slot.
    a_found_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_DONE && res_status_reg == lpht_pkg::ST_FOUND)
        |-> used_reg[res_idx_reg])
        else $error("search hit in an empty slot");

endmodule

FILE: hw/rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
